>>> rtl/lvn_pkg.sv
package lvn_pkg;

  localparam logic [31:0] HashKx   = 32'd1619;
  localparam logic [31:0] HashKy   = 32'd31337;
  localparam logic [31:0] HashKz   = 32'd6971;
  localparam logic [31:0] HashKs   = 32'd1013;
  localparam logic [31:0] PolyA    = 32'd60493;
  localparam logic [31:0] PolyB    = 32'd19990303;
  localparam logic [31:0] PolyC    = 32'd1376312589;
  localparam logic [30:0] HashMask = 31'h7fffffff;
  localparam int          NumCorners = 8;

  typedef enum logic {
    FUNC_HASH  = 1'b0,
    FUNC_NOISE = 1'b1
  } func_t;

  typedef struct packed {
    logic  valid;
    func_t func;
    logic  err;
  } ctl_t;

endpackage

>>> rtl/lvn_hash.sv
// Six-stage lattice hash pipeline. One point enters per cycle.
module lvn_hash
  import lvn_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] seed,
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] z,
  output logic [30:0] hash
);

  logic [31:0] px, py, pz, ps;
  logic [30:0] n1;
  logic [30:0] n2;
  logic [31:0] sq;
  logic [30:0] n3;
  logic [31:0] sqa;
  logic [30:0] n4;
  logic [31:0] pr;

  always_ff @(posedge clk) begin
    px  <= x * HashKx;
    py  <= y * HashKy;
    pz  <= z * HashKz;
    ps  <= seed * HashKs;
    n1  <= 31'(px + py + pz + ps);
    n2  <= n1 ^ (n1 >> 13);
    sq  <= {1'b0, n2} * {1'b0, n2};
    n3  <= n2;
    sqa <= sq * PolyA + PolyB;
    n4  <= n3;
    pr  <= sqa * {1'b0, n4};
  end

  assign hash = 31'(pr + PolyC) & HashMask;

endmodule

>>> rtl/lattice_value_noise_3d.sv
// Fully pipelined 3D value noise (mode 0 gives the raw hash): one item is
// taken every cycle (busy stays low) and its result appears with done, in
// order. The pipeline length is set by the six-stage hash followed by the
// three two-stage blend levels. The receiver cannot stall, so no result is
// ever held back. The eight corner hashes run in parallel copies of the
// hash pipeline while the smoothstep weights are computed alongside.
module lattice_value_noise_3d
  import lvn_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  input  logic        func,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  output logic        done,
  output logic [30:0] noise_value,
  output logic        coord_error
);

  localparam int HashLat = 6;
  localparam int Lat     = HashLat + 6;
  localparam int WW      = FRAC_BITS + 1;
  localparam logic [WW-1:0] One = WW'(1) << FRAC_BITS;

  logic [31:0] seed;
  ctl_t        ctl [Lat];
  logic [31:0] cx [NumCorners];
  logic [31:0] cy [NumCorners];
  logic [31:0] cz [NumCorners];
  logic [30:0] ch [NumCorners];
  logic [FRAC_BITS-1:0] fr [3];
  logic [WW-1:0] wt [3];
  logic [WW-1:0] wd [3][HashLat+2];
  logic [31:0] ax, ay, az;
  logic        neg;

  assign busy = 1'b0;
  assign ax = x_coord;
  assign ay = y_coord;
  assign az = z_coord;
  assign neg = ax[31] | ay[31] | az[31];
  assign fr[0] = ax[FRAC_BITS-1:0];
  assign fr[1] = ay[FRAC_BITS-1:0];
  assign fr[2] = az[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  // Corner coordinates; mode 0 hashes the raw point in every lane.
  always_comb begin
    logic [31:0] ix, iy, iz;
    ix = ax >> FRAC_BITS;
    iy = ay >> FRAC_BITS;
    iz = az >> FRAC_BITS;
    for (int c = 0; c < NumCorners; c++) begin
      if (func == FUNC_HASH) begin
        cx[c] = ax;
        cy[c] = ay;
        cz[c] = az;
      end else begin
        cx[c] = ix + 32'(c & 1);
        cy[c] = iy + 32'((c >> 1) & 1);
        cz[c] = iz + 32'((c >> 2) & 1);
      end
    end
  end

  for (genvar c = 0; c < NumCorners; c++) begin : g_hash
    lvn_hash u_hash (
      .clk (clk),
      .seed(seed),
      .x   (cx[c]),
      .y   (cy[c]),
      .z   (cz[c]),
      .hash(ch[c])
    );
  end

  // Smoothstep in two registered multiplies, then delayed to match.
  for (genvar a = 0; a < 3; a++) begin : g_wt
    logic [2*FRAC_BITS-1:0] f2;
    logic [FRAC_BITS+1:0]   k;
    logic [FRAC_BITS-1:0]   f2s;
    logic [2*FRAC_BITS+1:0] pr;
    always_ff @(posedge clk) begin
      f2  <= {{FRAC_BITS{1'b0}}, fr[a]} * {{FRAC_BITS{1'b0}}, fr[a]};
      k   <= (FRAC_BITS+2)'(3) * (FRAC_BITS+2)'(One) - ((FRAC_BITS+2)'(fr[a]) << 1);
      pr  <= (2*FRAC_BITS+2)'(f2[2*FRAC_BITS-1:FRAC_BITS]) * (2*FRAC_BITS+2)'(k);
      wd[a][0] <= WW'(pr >> FRAC_BITS);
      for (int i = 1; i < HashLat + 2; i++) begin
        wd[a][i] <= wd[a][i-1];
      end
    end
  end
  assign wt[0] = wd[0][HashLat-3];
  assign wt[1] = wd[1][HashLat-1];
  assign wt[2] = wd[2][HashLat+1];

  // Blend levels: products registered, then sum and shift registered.
  logic [31+WW:0] px0 [4], px1 [4];
  logic [30:0]    rx [4];
  logic [31+WW:0] py0 [2], py1 [2];
  logic [30:0]    ry [2];
  logic [31+WW:0] pz0, pz1;
  logic [30:0]    rz;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      px0[r] <= (32+WW)'(ch[2*r]) * (32+WW)'(One - wt[0]);
      px1[r] <= (32+WW)'(ch[2*r+1]) * (32+WW)'(wt[0]);
      rx[r]  <= 31'((px0[r] + px1[r]) >> FRAC_BITS);
    end
    for (int p = 0; p < 2; p++) begin
      py0[p] <= (32+WW)'(rx[2*p]) * (32+WW)'(One - wt[1]);
      py1[p] <= (32+WW)'(rx[2*p+1]) * (32+WW)'(wt[1]);
      ry[p]  <= 31'((py0[p] + py1[p]) >> FRAC_BITS);
    end
    pz0 <= (32+WW)'(ry[0]) * (32+WW)'(One - wt[2]);
    pz1 <= (32+WW)'(ry[1]) * (32+WW)'(wt[2]);
    rz  <= 31'((pz0 + pz1) >> FRAC_BITS);
  end

  // Control travels alongside; the raw hash is delayed to line up.
  logic [30:0] hd [6];
  always_ff @(posedge clk) begin
    hd[0] <= ch[0];
    for (int i = 1; i < 6; i++) begin
      hd[i] <= hd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lat; i++) begin
        ctl[i] <= '0;
      end
    end else begin
      ctl[0].valid <= start;
      ctl[0].func  <= func_t'(func);
      ctl[0].err   <= (func == FUNC_NOISE) && neg;
      for (int i = 1; i < Lat; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  assign done        = ctl[Lat-1].valid;
  assign coord_error = ctl[Lat-1].err;
  always_comb begin
    if (ctl[Lat-1].err) begin
      noise_value = '0;
    end else if (ctl[Lat-1].func == FUNC_HASH) begin
      noise_value = hd[5];
    end else begin
      noise_value = rz;
    end
  end

  a_err_only_noise: assert property (@(posedge clk) disable iff (rst)
    done && coord_error |-> ctl[Lat-1].func == FUNC_NOISE && noise_value == '0)
    else $error("error flag outside noise mode");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(Lat) done)
    else $error("result missing after pipeline latency");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Lat))
    else $error("result without a transfer");

endmodule

>>> tb/lattice_value_noise_3d_tb.sv
`timescale 1ns / 100ps

module lattice_value_noise_3d_tb;
  import lvn_pkg::*;

  localparam int FracBits = 16;
  localparam int PipeDepth = 12;
  localparam int StallLimit = 2000;

  typedef struct packed {
    func_t       func;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } sample_t;

  typedef struct packed {
    logic [30:0] value;
    logic        err;
  } noise_out_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        seed_we;
  logic [31:0] seed_wdata;
  logic        func;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_coord;
  logic        done;
  logic [30:0] noise_value;
  logic        coord_error;

  sample_t     pending_samples[$];
  noise_out_t  expected_noise[$];
  logic [31:0] model_seed;
  int          error_count;
  int          idle_cycles;
  int          gap_percent;
  bit          feed_enable;

  lattice_value_noise_3d #(.FRAC_BITS(FracBits)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seed_we(seed_we), .seed_wdata(seed_wdata), .func(func),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .done(done), .noise_value(noise_value), .coord_error(coord_error)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [30:0] corner_hash(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z, logic [31:0] s);
    logic [31:0] n;
    n = (x * HashKx + y * HashKy + z * HashKz + s * HashKs) & 32'h7fffffff;
    n = (n >> 13) ^ n;
    n = n * (n * n * PolyA + PolyB) + PolyC;
    return n[30:0];
  endfunction

  function automatic logic [63:0] fade(logic [63:0] f);
    logic [63:0] f2;
    f2 = (f * f) >> FracBits;
    return (f2 * ((64'd3 << FracBits) - 2 * f)) >> FracBits;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] w);
    return (a * ((64'd1 << FracBits) - w) + b * w) >> FracBits;
  endfunction

  function automatic noise_out_t predict_noise(sample_t smp, logic [31:0] s);
    noise_out_t  r;
    logic [31:0] ix, iy, iz, zz, fmask;
    logic [63:0] sx, sy, sz, r0, r1, acc;
    logic [63:0] plane[2];
    r.err = 1'b0;
    if (smp.func == FUNC_HASH) begin
      r.value = corner_hash(smp.x, smp.y, smp.z, s);
      return r;
    end
    if (smp.x[31] | smp.y[31] | smp.z[31]) begin
      r.value = '0;
      r.err = 1'b1;
      return r;
    end
    fmask = (32'd1 << FracBits) - 1;
    ix = smp.x >> FracBits;
    iy = smp.y >> FracBits;
    iz = smp.z >> FracBits;
    sx = fade(64'(smp.x & fmask));
    sy = fade(64'(smp.y & fmask));
    sz = fade(64'(smp.z & fmask));
    for (int k = 0; k < 2; k++) begin
      zz = iz + k;
      r0 = mix(64'(corner_hash(ix, iy, zz, s)), 64'(corner_hash(ix + 1, iy, zz, s)), sx);
      r1 = mix(64'(corner_hash(ix, iy + 1, zz, s)),
               64'(corner_hash(ix + 1, iy + 1, zz, s)), sx);
      plane[k] = mix(r0, r1, sy);
    end
    acc = mix(plane[0], plane[1], sz);
    r.value = acc[30:0];
    return r;
  endfunction

  // Random word biased toward the boundary values of a signed coordinate.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 255) << FracBits;
      default: return $urandom();
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t smp;
    smp.func = func_t'($urandom_range(0, 1));
    smp.x = rand_word();
    smp.y = rand_word();
    smp.z = rand_word();
    // Mode 1 with a negative coordinate only hits the error path, so keep most positive.
    if (smp.func == FUNC_NOISE && $urandom_range(0, 9) != 0) begin
      smp.x[31] = 1'b0;
      smp.y[31] = 1'b0;
      smp.z[31] = 1'b0;
    end
    return smp;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // The transfer happened at this edge; the model uses the seed now in force.
      expected_noise.push_back(predict_noise('{func_t'(func), x_coord, y_coord, z_coord},
                                             model_seed));
      if (feed_enable && pending_samples.size() > 0 && $urandom_range(0, 99) >= gap_percent)
      begin
        sample_t smp;
        smp = pending_samples.pop_front();
        func <= smp.func;
        x_coord <= smp.x;
        y_coord <= smp.y;
        z_coord <= smp.z;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && feed_enable && pending_samples.size() > 0 &&
                 $urandom_range(0, 99) >= gap_percent) begin
      sample_t smp;
      smp = pending_samples.pop_front();
      start <= 1'b1;
      func <= smp.func;
      x_coord <= smp.x;
      y_coord <= smp.y;
      z_coord <= smp.z;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_noise.size() == 0) begin
          $display("%0t: unexpected result value=%h err=%b", $time, noise_value, coord_error);
          error_count++;
        end else begin
          noise_out_t exp_r;
          exp_r = expected_noise.pop_front();
          if (noise_value !== exp_r.value) begin
            $display("%0t: noise_value expected %h actual %h", $time, exp_r.value,
                     noise_value);
            error_count++;
          end
          if (coord_error !== exp_r.err) begin
            $display("%0t: coord_error expected %b actual %b", $time, exp_r.err,
                     coord_error);
            error_count++;
          end
        end
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("lattice_value_noise_3d verification failed");
        $finish;
      end
    end
  end

  task automatic drain_and_wait();
    while (pending_samples.size() > 0 || start || expected_noise.size() > 0)
      @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] s);
    seed_we <= 1'b1;
    seed_wdata <= s;
    @(posedge clk);
    model_seed = s;
    seed_we <= 1'b0;
  endtask

  task automatic add(func_t f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pending_samples.push_back('{f, x, y, z});
  endtask

  initial begin
    logic [31:0] seeds[5];
    seeds = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h1234_5678};
    rst = 1'b1;
    start = 1'b0;
    seed_we = 1'b0;
    seed_wdata = '0;
    func = 1'b0;
    x_coord = '0;
    y_coord = '0;
    z_coord = '0;
    model_seed = '0;
    error_count = 0;
    idle_cycles = 0;
    gap_percent = 36;
    feed_enable = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, both modes, negative coordinates in mode 1.
    add(FUNC_HASH, 32'h0, 32'h0, 32'h0);
    add(FUNC_HASH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add(FUNC_HASH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add(FUNC_HASH, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
    add(FUNC_NOISE, 32'h0, 32'h0, 32'h0);
    add(FUNC_NOISE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add(FUNC_NOISE, 32'h0000_ffff, 32'h0000_8000, 32'h0001_0000);
    add(FUNC_NOISE, 32'h7fff_0000, 32'h0, 32'h0000_ffff);
    add(FUNC_NOISE, 32'h8000_0000, 32'h0, 32'h0);
    add(FUNC_NOISE, 32'h0, 32'hffff_ffff, 32'h0);
    add(FUNC_NOISE, 32'h0, 32'h0, 32'h8000_0001);
    add(FUNC_NOISE, 32'h0001_2345, 32'h0, 32'h0);
    add(FUNC_NOISE, 32'h0001_2345, 32'h0002_8000, 32'h0);
    feed_enable = 1'b1;
    drain_and_wait();

    for (int ph = 0; ph < 5; ph++) begin
      feed_enable = 1'b0;
      write_seed(ph == 4 ? $urandom() : seeds[ph]);
      // The second random phase runs back to back with no gaps.
      gap_percent = (ph == 1) ? 0 : 36;
      for (int i = 0; i < 208; i++) pending_samples.push_back(rand_sample());
      feed_enable = 1'b1;
      drain_and_wait();
    end

    if (error_count == 0) begin
      $display("lattice_value_noise_3d verification clean");
    end else begin
      $display("lattice_value_noise_3d verification failed");
    end
    $finish;
  end

endmodule

>>> lattice_value_noise_3d.f
rtl/lvn_pkg.sv
rtl/lvn_hash.sv
rtl/lattice_value_noise_3d.sv
tb/lattice_value_noise_3d_tb.sv
